### rtl/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace unit.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 8;
    localparam int REG_BYTES             = 8;
    localparam int QUEUE_DEPTH_DEF       = 2;
    localparam int CFG_IDX_W             = 3;
    localparam int CFG_DATA_W            = 64;
    localparam int LEN_W                 = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN   = 3'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } out_t;

    typedef struct packed {
        logic [REG_BYTES*8-1:0] bytes;
        logic [LEN_W-1:0]       count;
        logic                   last;
    } cmd_t;

endpackage

### rtl/sfr_front.sv
// Front end: configuration registers, match window and command generation.
`timescale 1ns / 1ps

module sfr_front #(
    parameter int MAX_PATTERN_BYTES = sfr_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             in_fire,
    input  sfr_pkg::in_t                     in_data,
    output logic                             cmd_push,
    output sfr_pkg::cmd_t                    cmd_data
);

    localparam int LEN_CAP = (MAX_PATTERN_BYTES < sfr_pkg::REG_BYTES) ?
                             MAX_PATTERN_BYTES : sfr_pkg::REG_BYTES;
    localparam int CNT_W   = $clog2(LEN_CAP + 1);
    localparam int LW      = sfr_pkg::LEN_W;

    logic [63:0]    pat_bytes_reg, pat_bytes_next;
    logic [LW-1:0]  pat_len_reg, pat_len_next;
    logic [63:0]    rep_bytes_reg, rep_bytes_next;
    logic [LW-1:0]  rep_len_reg, rep_len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]     win_reg [LEN_CAP];
    logic [7:0]     win_next [LEN_CAP];

    logic [7:0]     app [LEN_CAP];
    logic [7:0]     shifted [LEN_CAP];
    logic [LW-1:0]  plen4, rlen4;
    logic [CNT_W-1:0] plen, cnt_eff, cnt_inc;
    logic           full, hit;

    always_comb begin
        if (pat_len_reg == '0) begin
            plen4 = LW'(1);
        end else if (pat_len_reg > LW'(LEN_CAP)) begin
            plen4 = LW'(LEN_CAP);
        end else begin
            plen4 = pat_len_reg;
        end
        if (rep_len_reg > LW'(LEN_CAP)) begin
            rlen4 = LW'(LEN_CAP);
        end else begin
            rlen4 = rep_len_reg;
        end
    end

    assign plen    = CNT_W'(plen4);
    assign cnt_eff = (cnt_reg >= plen) ? '0 : cnt_reg;
    assign cnt_inc = cnt_eff + CNT_W'(1);
    assign full    = (cnt_inc == plen);

    always_comb begin
        for (int i = 0; i < LEN_CAP; i++) begin
            app[i] = (CNT_W'(i) == cnt_eff) ? in_data.in_byte : win_reg[i];
        end
        for (int i = 0; i < LEN_CAP - 1; i++) begin
            shifted[i] = app[i + 1];
        end
        shifted[LEN_CAP-1] = app[LEN_CAP-1];
        hit = 1'b1;
        for (int i = 0; i < LEN_CAP; i++) begin
            if ((CNT_W'(i) < plen) && (app[i] != pat_bytes_reg[8*i +: 8])) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        cmd_data       = '0;
        cmd_data.last  = in_data.in_last;
        if (full && hit) begin
            cmd_data.bytes = rep_bytes_reg;
            cmd_data.count = rlen4;
        end else begin
            for (int i = 0; i < LEN_CAP; i++) begin
                cmd_data.bytes[8*i +: 8] = app[i];
            end
            if (in_data.in_last) begin
                cmd_data.count = LW'(cnt_inc);
            end else begin
                cmd_data.count = LW'(1);
            end
        end
        cmd_push = in_fire &&
                   (in_data.in_last || (full && (!hit || (rlen4 != '0))));
    end

    always_comb begin
        pat_bytes_next = pat_bytes_reg;
        pat_len_next   = pat_len_reg;
        rep_bytes_next = rep_bytes_reg;
        rep_len_next   = rep_len_reg;
        cnt_next       = cnt_reg;
        win_next       = win_reg;
        if (in_fire) begin
            if (full) begin
                win_next = shifted;
            end else begin
                win_next = app;
            end
            if (in_data.in_last || (full && hit)) begin
                cnt_next = '0;
            end else if (full) begin
                cnt_next = cnt_eff;
            end else begin
                cnt_next = cnt_inc;
            end
        end
        if (cfg_we) begin
            case (cfg_index)
                sfr_pkg::REG_PATTERN_BYTES: begin
                    pat_bytes_next = cfg_wdata;
                    cnt_next       = '0;
                end
                sfr_pkg::REG_PATTERN_LEN: begin
                    pat_len_next = cfg_wdata[LW-1:0];
                    cnt_next     = '0;
                end
                sfr_pkg::REG_REPLACE_BYTES: begin
                    rep_bytes_next = cfg_wdata;
                end
                sfr_pkg::REG_REPLACE_LEN: begin
                    rep_len_next = cfg_wdata[LW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= LW'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            cnt_reg       <= '0;
        end else begin
            pat_bytes_reg <= pat_bytes_next;
            pat_len_reg   <= pat_len_next;
            rep_bytes_reg <= rep_bytes_next;
            rep_len_reg   <= rep_len_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

### rtl/sfr_queue.sv
// Command queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module sfr_queue #(
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sfr_pkg::cmd_t push_data,
    input  logic          pop,
    output sfr_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfr_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

### rtl/sfr_back.sv
// Back end: expands queued commands into output transactions.
`timescale 1ns / 1ps

module sfr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  sfr_pkg::cmd_t q_data,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output sfr_pkg::out_t m_data
);

    localparam int LW    = sfr_pkg::LEN_W;
    localparam int IDX_W = $clog2(sfr_pkg::REG_BYTES);

    sfr_pkg::cmd_t cmd_reg, cmd_next;
    logic          busy_reg, busy_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic          final_elem, take;

    assign final_elem = (cmd_reg.count == '0) || ((idx_reg + LW'(1)) == cmd_reg.count);
    assign take       = !busy_reg || (m_ready && final_elem);
    assign q_pop      = take && !q_empty;
    assign m_valid    = busy_reg;

    always_comb begin
        m_data.out_valid = (cmd_reg.count != '0);
        m_data.out_byte  = m_data.out_valid ? cmd_reg.bytes[8*idx_reg[IDX_W-1:0] +: 8] : 8'd0;
        m_data.out_last  = cmd_reg.last && final_elem;
    end

    always_comb begin
        cmd_next  = cmd_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take) begin
            busy_next = !q_empty;
            cmd_next  = q_data;
            idx_next  = '0;
        end else if (m_ready) begin
            idx_next = idx_reg + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

endmodule

### rtl/stream_find_replace_unit.sv
// Top level of the stream find-and-replace unit.
// Path: with the output sequencer idle, the command for a byte is registered in the
// command queue and then in the sequencer's command register, which offers its first result.
// Throughput: one input byte per cycle; a command of n results holds the output
// sequencer until all n are taken, and input stalls once the command queue is full.
// Reset: synchronous active-low aresetn clears the queue, window count and
// registers (pattern length 1, all else 0); window bytes are not reset.
`timescale 1ns / 1ps

module stream_find_replace_unit #(
    parameter int MAX_PATTERN_BYTES = sfr_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int QUEUE_DEPTH       = sfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sfr_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sfr_pkg::out_t                  m_data
);

    logic          cmd_push, q_pop, q_full, q_empty;
    sfr_pkg::cmd_t cmd_data, q_data;

    assign s_ready = !q_full;

    sfr_front #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_fire  (s_valid && s_ready),
        .in_data  (s_data),
        .cmd_push (cmd_push),
        .cmd_data (cmd_data)
    );

    sfr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_data(cmd_data),
        .pop      (q_pop),
        .pop_data (q_data),
        .full     (q_full),
        .empty    (q_empty)
    );

    sfr_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .q_data (q_data),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd_push && q_full))
        else $error("command pushed into a full queue");

    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.out_valid || m_data.out_last))
        else $error("empty marker without last flag");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule
